### hdl/smtp_command_line_parser_defines.svh
// Assertion helpers used by the checker file
`ifndef SMTP_COMMAND_LINE_PARSER_DEFINES_SVH
`define SMTP_COMMAND_LINE_PARSER_DEFINES_SVH
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/scp_pkg.sv
package scp_pkg;
    localparam int LINE_MAX = 1024;
    localparam int OW = $clog2(LINE_MAX);
    localparam logic [OW-1:0] SAT_MAX = OW'(LINE_MAX - 1);
    localparam int QDEPTH = 2;

    localparam logic [3:0] C_HELO     = 4'd0;
    localparam logic [3:0] C_EHLO     = 4'd1;
    localparam logic [3:0] C_MAIL     = 4'd2;
    localparam logic [3:0] C_RCPT     = 4'd3;
    localparam logic [3:0] C_DATA     = 4'd4;
    localparam logic [3:0] C_RSET     = 4'd5;
    localparam logic [3:0] C_VRFY     = 4'd6;
    localparam logic [3:0] C_EXPN     = 4'd7;
    localparam logic [3:0] C_HELP     = 4'd8;
    localparam logic [3:0] C_NOOP     = 4'd9;
    localparam logic [3:0] C_QUIT     = 4'd10;
    localparam logic [3:0] C_STARTTLS = 4'd11;
    localparam logic [3:0] C_AUTH     = 4'd12;
    // token that names no command
    localparam logic [3:0] C_NONE     = 4'hf;

    typedef enum logic [4:0] {
        PH_LEAD = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_SKIP = 5'b00100,
        PH_GAP  = 5'b01000,
        PH_ARG  = 5'b10000
    } t_phase;

    // Line summary handed from the front to the back
    typedef struct packed {
        logic [3:0]    cmd;
        logic          kw;
        logic          long_line;
        logic [1:0]    ntok;
        logic [OW-1:0] le;
        logic [OW-1:0] ae;
        logic [OW-1:0] p0;
        logic [OW-1:0] p1;
        logic [OW-1:0] p2;
        logic [OW-1:0] p3;
        logic [OW-1:0] p4;
        logic [15:0]   idx;
    } t_line;

    typedef struct packed {
        logic [3:0]    cmd;
        logic          has;
        logic          kw;
        logic [OW-1:0] ab;
        logic [OW-1:0] ae;
        logic [OW-1:0] ps;
        logic [OW-1:0] pe;
        logic [OW-1:0] xs;
        logic [OW-1:0] xe;
        logic [15:0]   idx;
        logic          long_line;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

    // Returns command code or C_NONE when the token is no command
    function automatic logic [3:0] match_cmd(input logic [63:0] t, input logic [3:0] n);
        logic [3:0] r;
        r = C_NONE;
        if (n == 4'd4) begin
            unique case (t[31:0])
                "OLEH": r = C_HELO;
                "OLHE": r = C_EHLO;
                "LIAM": r = C_MAIL;
                "TPCR": r = C_RCPT;
                "ATAD": r = C_DATA;
                "TESR": r = C_RSET;
                "YFRV": r = C_VRFY;
                "NPXE": r = C_EXPN;
                "PLEH": r = C_HELP;
                "POON": r = C_NOOP;
                "TIUQ": r = C_QUIT;
                "HTUA": r = C_AUTH;
                default: r = C_NONE;
            endcase
        end else if (n == 4'd8 && t == "SLTTRATS") begin
            r = C_STARTTLS;
        end
        return r;
    endfunction
endpackage

### hdl/smtp_command_line_parser.sv
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata = data_byte, tuser = last_of_message
// m_axis    out  m_axis_tvalid/tready  tdata = result fields, packed
// cfg       in   i_cfg_valid/o_cfg_ready  packet_limit
// One byte per cycle while the queue has room; a result passes from its accepted LF
// through a two-entry queue and then an output register, so bytes keep flowing while the
// output is stalled.
// Input stalls only when the queue holds two undelivered lines.
// Synchronous active-low reset clears all line state and sets the limit to 65535.
module smtp_command_line_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic         s_axis_tuser,  // last_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // command[3:0], has_argument, keyword_found, arg_start, arg_end, path_start,
    // path_end, extra_start, extra_end (10 each), packet_index[15:0], line_overlong
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);
    logic [15:0] r_limit;
    logic q_push, q_full, q_valid, q_pop;
    scp_pkg::t_line f_line, q_line;
    scp_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 16'hffff;
        else if (i_cfg_valid) r_limit <= i_cfg_data;
    end

    scp_front u_front (
        .i_clk, .i_rst_n, .i_limit(r_limit), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_byte(s_axis_tdata), .i_last(s_axis_tuser),
        .o_push(q_push), .o_line(f_line), .i_full(q_full)
    );
    scp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_line(f_line), .o_full(q_full),
        .o_valid(q_valid), .o_line(q_line), .i_pop(q_pop)
    );
    scp_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_line(q_line), .o_pop(q_pop),
        .o_valid(m_axis_tvalid), .o_res(res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, res.long_line, res.idx, res.xe, res.xs, res.pe,
        res.ps, res.ae, res.ab, res.kw, res.has, res.cmd};
endmodule

### hdl/scp_front.sv
module scp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_limit,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output scp_pkg::t_line o_line,
    input  logic           i_full
);
    localparam int OW = scp_pkg::OW;

    scp_pkg::t_phase r_ph, n_ph;
    logic [OW-1:0] r_off, n_off;
    logic [63:0]   r_tok, n_tok;
    logic [3:0]    r_tlen, n_tlen;
    logic [OW-1:0] r_pos [0:4];
    logic [OW-1:0] n_pos [0:4];
    logic [OW-1:0] r_lnb, n_lnb;
    logic          r_long, n_long, r_cr, n_cr, r_kw, n_kw;
    logic [3:0]    r_cmd, n_cmd;
    logic [1:0]    r_ntok, n_ntok;
    logic [15:0]   r_cnt, n_cnt;

    logic acc;
    assign o_ready = !i_full;
    assign acc = i_valid && o_ready;

    function automatic logic kw_at_end();
        return r_kw || (r_ph == scp_pkg::PH_ARG && r_ntok == 2'd0 &&
            ((r_cmd == scp_pkg::C_MAIL && r_tlen == 4'd5 && r_tok[39:0] == ":MORF") ||
             (r_cmd == scp_pkg::C_RCPT && r_tlen == 4'd3 && r_tok[23:0] == ":OT")));
    endfunction

    always_comb begin
        logic [7:0] c;
        logic ws, feed, emit;
        logic [OW-1:0] pos;
        logic [3:0] m;
        n_ph = r_ph; n_off = r_off; n_tok = r_tok; n_tlen = r_tlen;
        n_pos = r_pos; n_lnb = r_lnb; n_long = r_long; n_cr = r_cr;
        n_kw = r_kw; n_cmd = r_cmd; n_ntok = r_ntok; n_cnt = r_cnt;
        o_push = 1'b0;
        emit = 1'b0;
        m = scp_pkg::C_NONE;
        c = 8'h0d;
        feed = 1'b0;
        ws = 1'b0;
        pos = '0;
        if (i_byte == 8'h0a) begin
            // close the open token at line end
            if (r_ph == scp_pkg::PH_CMD) begin
                m = scp_pkg::match_cmd(r_tok, r_tlen);
                n_cmd = m;
                emit = (m != scp_pkg::C_NONE);
            end else if (r_ph == scp_pkg::PH_ARG || r_ph == scp_pkg::PH_GAP) begin
                emit = 1'b1;
            end
            o_push = acc && emit && (r_cnt < i_limit);
            if (o_push) n_cnt = r_cnt + 16'd1;
            n_ph = scp_pkg::PH_LEAD; n_off = '0; n_tok = '0; n_tlen = '0;
            n_lnb = '0; n_long = 1'b0; n_cr = 1'b0; n_kw = 1'b0; n_cmd = '0;
            n_ntok = '0;
            for (int k = 0; k < 5; k++) n_pos[k] = '0;
        end else begin
            // a held CR first, then this byte if it is no CR
            if (r_cr) begin
                c = 8'h0d; feed = 1'b1; n_cr = 1'b0;
                if (i_byte == 8'h0d) n_cr = 1'b1;
            end
            for (int s = 0; s < 2; s++) begin
                if (s == 1) begin
                    feed = (i_byte != 8'h0d);
                    c = i_byte;
                    if (i_byte == 8'h0d) n_cr = 1'b1;
                end
                if (feed) begin
                    ws = (c == 8'h20 || c == 8'h09);
                    pos = n_off;
                    if (n_off >= scp_pkg::SAT_MAX) begin
                        n_off = scp_pkg::SAT_MAX; n_long = 1'b1;
                    end else begin
                        n_off = n_off + OW'(1);
                    end
                    unique case (n_ph)
                        scp_pkg::PH_LEAD: if (!ws) begin
                            n_tok = {56'd0, scp_pkg::fold(c)}; n_tlen = 4'd1;
                            n_ph = scp_pkg::PH_CMD;
                        end
                        scp_pkg::PH_CMD: begin
                            if (ws) begin
                                m = scp_pkg::match_cmd(n_tok, n_tlen);
                                if (m != scp_pkg::C_NONE) begin
                                    n_cmd = m; n_ph = scp_pkg::PH_GAP;
                                    n_tok = '0; n_tlen = '0;
                                end else begin
                                    n_ph = scp_pkg::PH_SKIP;
                                end
                            end else begin
                                if (n_tlen < 4'd8)
                                    n_tok[n_tlen[2:0]*8 +: 8] = scp_pkg::fold(c);
                                if (n_tlen < 4'd15) n_tlen = n_tlen + 4'd1;
                            end
                        end
                        scp_pkg::PH_GAP: if (!ws) begin
                            if (n_ntok != 2'd3) n_pos[3'({n_ntok, 1'b0})] = pos;
                            if (n_ntok == 2'd0) begin
                                n_tok = {56'd0, scp_pkg::fold(c)}; n_tlen = 4'd1;
                            end
                            n_ph = scp_pkg::PH_ARG;
                            n_lnb = n_off;
                        end
                        scp_pkg::PH_ARG: begin
                            if (ws) begin
                                if (n_ntok == 2'd0 && ((n_cmd == scp_pkg::C_MAIL &&
                                        n_tlen == 4'd5 && n_tok[39:0] == ":MORF") ||
                                        (n_cmd == scp_pkg::C_RCPT && n_tlen == 4'd3 &&
                                        n_tok[23:0] == ":OT")))
                                    n_kw = 1'b1;
                                if (n_ntok == 2'd0) n_pos[1] = pos;
                                else if (n_ntok == 2'd1) n_pos[3] = pos;
                                if (n_ntok != 2'd3) n_ntok = n_ntok + 2'd1;
                                n_ph = scp_pkg::PH_GAP;
                            end else begin
                                if (n_ntok == 2'd0) begin
                                    if (n_tlen < 4'd8)
                                        n_tok[n_tlen[2:0]*8 +: 8] = scp_pkg::fold(c);
                                    if (n_tlen < 4'd15) n_tlen = n_tlen + 4'd1;
                                end
                                n_lnb = n_off;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (i_last) begin
            n_ph = scp_pkg::PH_LEAD; n_off = '0; n_tok = '0; n_tlen = '0;
            n_lnb = '0; n_long = 1'b0; n_cr = 1'b0; n_kw = 1'b0; n_cmd = '0;
            n_ntok = '0; n_cnt = '0;
            for (int k = 0; k < 5; k++) n_pos[k] = '0;
        end
    end

    // line summary uses the pre-clear view for the end-of-line fields
    always_comb begin
        o_line.cmd = (r_ph == scp_pkg::PH_CMD) ? scp_pkg::match_cmd(r_tok, r_tlen) : r_cmd;
        o_line.kw = kw_at_end();
        o_line.long_line = r_long;
        o_line.ntok = (r_ph == scp_pkg::PH_ARG && r_ntok != 2'd3) ? r_ntok + 2'd1 : r_ntok;
        o_line.le = r_off;
        o_line.ae = r_lnb;
        o_line.p0 = r_pos[0];
        o_line.p1 = (r_ph == scp_pkg::PH_ARG && r_ntok == 2'd0) ? r_off : r_pos[1];
        o_line.p2 = r_pos[2];
        o_line.p3 = (r_ph == scp_pkg::PH_ARG && r_ntok == 2'd1) ? r_off : r_pos[3];
        o_line.p4 = r_pos[4];
        o_line.idx = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= scp_pkg::PH_LEAD; r_off <= '0; r_tok <= '0; r_tlen <= '0;
            r_lnb <= '0; r_long <= 1'b0; r_cr <= 1'b0; r_kw <= 1'b0;
            r_cmd <= '0; r_ntok <= '0; r_cnt <= '0;
            for (int k = 0; k < 5; k++) r_pos[k] <= '0;
        end else if (acc) begin
            r_ph <= n_ph; r_off <= n_off; r_tok <= n_tok; r_tlen <= n_tlen;
            r_lnb <= n_lnb; r_long <= n_long; r_cr <= n_cr; r_kw <= n_kw;
            r_cmd <= n_cmd; r_ntok <= n_ntok; r_cnt <= n_cnt;
            r_pos <= n_pos;
        end
    end
endmodule

### hdl/scp_queue.sv
module scp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scp_pkg::t_line i_line,
    output logic           o_full,
    output logic           o_valid,
    output scp_pkg::t_line o_line,
    input  logic           i_pop
);
    localparam int AW = $clog2(scp_pkg::QDEPTH);
    scp_pkg::t_line r_mem [0:scp_pkg::QDEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(scp_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_line  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

### hdl/scp_back.sv
module scp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  scp_pkg::t_line   i_line,
    output logic             o_pop,
    output logic             o_valid,
    output scp_pkg::t_result o_res,
    input  logic             i_ready
);
    scp_pkg::t_result n_res;
    logic r_valid;

    assign o_valid = r_valid;
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        logic has;
        has = (i_line.ntok != 2'd0);
        n_res.cmd = i_line.cmd;
        n_res.has = has;
        n_res.kw = i_line.kw;
        n_res.ab = has ? i_line.p0 : i_line.le;
        n_res.ae = has ? i_line.ae : i_line.le;
        n_res.ps = n_res.ae; n_res.pe = n_res.ae;
        n_res.xs = n_res.ae; n_res.xe = n_res.ae;
        n_res.idx = i_line.idx;
        n_res.long_line = i_line.long_line;
        unique case (i_line.cmd)
            scp_pkg::C_HELO, scp_pkg::C_EHLO, scp_pkg::C_VRFY, scp_pkg::C_EXPN,
            scp_pkg::C_HELP: begin
                n_res.ps = n_res.ab; n_res.pe = n_res.ae;
            end
            scp_pkg::C_MAIL, scp_pkg::C_RCPT: begin
                if (i_line.kw) begin
                    if (i_line.ntok >= 2'd2) begin
                        n_res.ps = i_line.p2; n_res.pe = i_line.p3;
                    end
                    if (i_line.ntok == 2'd3) n_res.xs = i_line.p4;
                end else begin
                    n_res.ps = n_res.ab; n_res.pe = n_res.ae;
                end
            end
            scp_pkg::C_AUTH: if (has) begin
                n_res.ps = i_line.p0; n_res.pe = i_line.p1;
                if (i_line.ntok >= 2'd2) n_res.xs = i_line.p2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) o_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_pop) r_valid <= 1'b1;
        else if (i_ready) r_valid <= 1'b0;
    end
endmodule

### hdl/scp_checker.sv
`include "smtp_command_line_parser_defines.svh"
module scp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    `SCP_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `SCP_ASSERT_IMP(a_cmd, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd12, "bad command code")
    `SCP_ASSERT_IMP(a_arg, m_axis_tvalid, m_axis_tdata[15:6] <= m_axis_tdata[25:16], "argument start after end")
    `SCP_ASSERT_IMP(a_noarg, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[15:6] == m_axis_tdata[25:16], "empty argument not empty")
endmodule
bind smtp_command_line_parser scp_checker u_chk (.*);
